### hw/rtl/sm4_pkg.sv
// Package: SM4 S-box, constants, round helpers and shared types.
`timescale 1ns / 1ps
package sm4_pkg;

    localparam int unsigned ROUNDS = 32;
    localparam int unsigned RK_IDX_W = 5;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 2'd2;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;
    localparam logic [7:0] CK_STEP = 8'h07;

    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } t_words;

    typedef struct packed {
        logic   vld;
        t_words x;
    } t_stage;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] tau(input logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] lin_data(input logic [31:0] b);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic logic [31:0] lin_key(input logic [31:0] b);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    function automatic logic [31:0] ck_word(input logic [RK_IDX_W-1:0] i);
        logic [7:0] base;
        base = CK_STEP * {1'b0, i, 2'b00};
        return {base, base + CK_STEP, base + 8'(2 * CK_STEP), base + 8'(3 * CK_STEP)};
    endfunction

endpackage

### hw/rtl/sm4_key_sched.sv
// Key schedule: registered chain that builds the 32 round keys, one per step.
`timescale 1ns / 1ps
module sm4_key_sched (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [63:0]                 i_key_high,
    input  logic [63:0]                 i_key_low,
    output logic [sm4_pkg::ROUNDS-1:0][31:0] o_rk,
    output logic                        o_ready
);
    import sm4_pkg::*;

    t_words                   r_k;
    t_words                   n_k;
    logic [RK_IDX_W-1:0]      r_idx;
    logic                     r_run;
    logic [ROUNDS-1:0][31:0]  r_rk;
    logic [31:0]              nk;

    assign nk = r_k.w0 ^ lin_key(tau(r_k.w1 ^ r_k.w2 ^ r_k.w3 ^ ck_word(r_idx)));

    always_comb begin
        n_k = '{w0: r_k.w1, w1: r_k.w2, w2: r_k.w3, w3: nk};
        if (i_load) begin
            n_k = '{w0: i_key_high[63:32] ^ FK0, w1: i_key_high[31:0] ^ FK1,
                    w2: i_key_low[63:32] ^ FK2, w3: i_key_low[31:0] ^ FK3};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b1;
            r_idx <= '0;
            r_k   <= '{w0: FK0, w1: FK1, w2: FK2, w3: FK3};
        end else begin
            r_k <= n_k;
            if (i_load) begin
                r_run <= 1'b1;
                r_idx <= '0;
            end else if (r_run) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == RK_IDX_W'(ROUNDS - 1)) r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_run && !i_load) r_rk[r_idx] <= nk;
    end

    assign o_rk    = r_rk;
    assign o_ready = !r_run;
endmodule

### hw/rtl/sm4_round_cell.sv
// Round cell: one SM4 round with its own stage register.
`timescale 1ns / 1ps
module sm4_round_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sm4_pkg::t_stage i_stage,
    input  logic [31:0]     i_rk,
    output sm4_pkg::t_stage o_stage
);
    import sm4_pkg::*;

    t_stage      r_stage;
    logic [31:0] nx;

    assign nx = i_stage.x.w0 ^ lin_data(tau(i_stage.x.w1 ^ i_stage.x.w2 ^ i_stage.x.w3 ^ i_rk));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_stage.vld <= 1'b0;
        else          r_stage.vld <= i_stage.vld;
        r_stage.x <= '{w0: i_stage.x.w1, w1: i_stage.x.w2, w2: i_stage.x.w3, w3: nx};
    end

    assign o_stage = r_stage;
endmodule

### hw/rtl/sm4_block_cipher.sv
// Top level: SM4 ECB cipher, 32-cell round pipeline with key schedule.
`timescale 1ns / 1ps
// One 128-bit block is taken per cycle while busy is low; each result passes through
// the chain of 32 round cells, one round per cell, and is flagged by a pulse on
// o_done for one cycle. A write of either key half starts the key schedule, which
// builds one round key per cycle; busy is high until all 32 are done (also after reset).
module sm4_block_cipher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sm4_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sm4_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [63:0]                     i_block_high,
    input  logic [63:0]                     i_block_low,
    output logic                            o_done,
    output logic [63:0]                     o_result_high,
    output logic [63:0]                     o_result_low
);
    import sm4_pkg::*;

    logic [63:0]             r_key_high;
    logic [63:0]             r_key_low;
    logic                    r_decrypt;
    logic                    key_load;
    logic                    ks_ready;
    logic [ROUNDS-1:0][31:0] rk;
    t_stage                  chain [ROUNDS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_decrypt  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_DECRYPT:  r_decrypt  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign key_load = i_cfg_we && (i_cfg_idx == CFG_KEY_HIGH || i_cfg_idx == CFG_KEY_LOW);

    sm4_key_sched u_ks (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (key_load),
        .i_key_high (i_cfg_idx == CFG_KEY_HIGH ? i_cfg_data : r_key_high),
        .i_key_low  (i_cfg_idx == CFG_KEY_LOW ? i_cfg_data : r_key_low),
        .o_rk       (rk),
        .o_ready    (ks_ready)
    );

    assign busy = !ks_ready;

    assign chain[0].vld = start && !busy;
    assign chain[0].x   = '{w0: i_block_high[63:32], w1: i_block_high[31:0],
                            w2: i_block_low[63:32], w3: i_block_low[31:0]};

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        sm4_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (chain[g]),
            .i_rk    (r_decrypt ? rk[ROUNDS-1-g] : rk[g]),
            .o_stage (chain[g+1])
        );
    end

    assign o_done        = chain[ROUNDS].vld;
    assign o_result_high = {chain[ROUNDS].x.w3, chain[ROUNDS].x.w2};
    assign o_result_low  = {chain[ROUNDS].x.w1, chain[ROUNDS].x.w0};

    a_first_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> chain[1].vld) else $error("request lost at first cell");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(chain[ROUNDS-1].vld)) else $error("result without request");
    a_keys_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_load |=> busy) else $error("key schedule not busy after key write");
endmodule
